### design/isbr_pkg.sv
// Shared types and constants for the I2C stuck-bus recovery sequencer.
// No dependencies; every other design file imports this package.
`default_nettype none

package isbr_pkg;

    typedef struct packed {
        logic action;
        logic sda_in;
        logic scl_in;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] outcome;
    } rsp_item_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_CLKLO,
        PH_CLKHI,
        PH_STOPA,
        PH_STOPB,
        PH_STOPC
    } phase_t;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CLK_CNT_BITS   = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_TICKS     = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RECOVERY_CLOCKS = 1'd1;

    localparam logic [CFG_DATA_BITS-1:0] PULSE_TICKS_RESET     = 16'd250;
    localparam logic [CLK_CNT_BITS-1:0]  RECOVERY_CLOCKS_RESET = 4'd9;

    localparam logic [1:0] OUTCOME_CLEAN = 2'd0;
    localparam logic [1:0] OUTCOME_FULL  = 2'd1;
    localparam logic [1:0] OUTCOME_CUT   = 2'd2;

endpackage

`default_nettype wire

### design/i2c_stuck_bus_recovery_top.sv
// I2C stuck-bus recovery sequencer: one command item per timebase tick in,
// one result item per tick out, with the drive enables and status after that
// tick. Takes one item every cycle while the skid stage is empty; its result
// is registered in the output register, or in the skid stage while the output
// waits. That one-entry skid stage keeps the command side ready for one more
// item while a result is held by the consumer, so the sustained rate is one
// item per cycle whenever results are taken. Configuration is a single-cycle
// write port with no read-back. Depends on isbr_pkg, isbr_seq and isbr_skid.
`default_nettype none

module i2c_stuck_bus_recovery_top #(
    parameter int TICK_BITS = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [isbr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [isbr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire                                  cmd_valid,
    output logic                                 cmd_ready,
    input  isbr_pkg::cmd_item_t                  cmd,
    output logic                                 rsp_valid,
    input  wire                                  rsp_ready,
    output isbr_pkg::rsp_item_t                  rsp
);
    import isbr_pkg::*;

    logic      cmd_fire;
    rsp_item_t seq_rsp;

    assign cmd_fire = cmd_valid && cmd_ready;

    isbr_seq #(
        .TICK_BITS (TICK_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (cmd_fire),
        .cmd       (cmd),
        .rsp       (seq_rsp)
    );

    isbr_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd_fire),
        .load_item (seq_rsp),
        .space     (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

### design/isbr_seq.sv
// Recovery sequencer: configuration registers, phase state machine and
// per-item result logic. Depends on isbr_pkg.
`default_nettype none

module isbr_seq #(
    parameter int TICK_BITS = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [isbr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [isbr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire                                  fire,
    input  isbr_pkg::cmd_item_t                  cmd,
    output isbr_pkg::rsp_item_t                  rsp
);
    import isbr_pkg::*;

    localparam logic [31:0] TickMax = (TICK_BITS >= 32) ? 32'hFFFF_FFFF
                                    : ((32'd1 << TICK_BITS) - 32'd1);

    logic [CFG_DATA_BITS-1:0] pulse_ticks_reg;
    logic [CLK_CNT_BITS-1:0]  recovery_clocks_reg;

    phase_t                   phase_reg, phase_next;
    logic [TICK_BITS-1:0]     tick_reg, tick_next;
    logic [CLK_CNT_BITS-1:0]  clock_reg, clock_next;
    logic [1:0]               code_reg, code_next;

    logic [31:0]              target_wide;
    logic [31:0]              target_sat;
    logic [TICK_BITS-1:0]     target;
    logic [TICK_BITS-1:0]     tick_inc;
    logic [CLK_CNT_BITS-1:0]  clock_inc;
    logic                     done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg     <= PULSE_TICKS_RESET;
            recovery_clocks_reg <= RECOVERY_CLOCKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PULSE_TICKS:     pulse_ticks_reg     <= cfg_data;
                CFG_RECOVERY_CLOCKS: recovery_clocks_reg <= cfg_data[CLK_CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Saturate to the counter range, treat zero as one tick.
    always_comb
    begin
        target_wide = {{(32-CFG_DATA_BITS){1'b0}}, pulse_ticks_reg};
        target_sat  = (target_wide > TickMax) ? TickMax : target_wide;
        if (target_sat == 32'd0)
        begin
            target_sat = 32'd1;
        end
        target = target_sat[TICK_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            clock_reg <= '0;
            code_reg  <= OUTCOME_CLEAN;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            clock_reg <= clock_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        clock_next = clock_reg;
        code_next  = code_reg;
        done       = 1'b0;
        tick_inc   = tick_reg + 1'b1;
        clock_inc  = clock_reg + 1'b1;

        if (phase_reg == PH_IDLE)
        begin
            if (cmd.action)
            begin
                phase_next = PH_SETTLE;
                tick_next  = '0;
                clock_next = '0;
                code_next  = OUTCOME_CLEAN;
            end
        end
        else
        begin
            tick_next = tick_inc;
            if (tick_inc >= target)
            begin
                tick_next = '0;
                case (phase_reg)
                    PH_SETTLE:
                    begin
                        // Recover only when SDA is held low with SCL released.
                        if (!cmd.sda_in && cmd.scl_in)
                        begin
                            if (recovery_clocks_reg == '0)
                            begin
                                code_next  = OUTCOME_FULL;
                                phase_next = PH_STOPA;
                            end
                            else
                            begin
                                phase_next = PH_CLKLO;
                            end
                        end
                        else
                        begin
                            code_next  = OUTCOME_CLEAN;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_CLKLO: phase_next = PH_CLKHI;
                    PH_CLKHI:
                    begin
                        clock_next = clock_inc;
                        if (clock_inc >= recovery_clocks_reg)
                        begin
                            code_next  = OUTCOME_FULL;
                            phase_next = PH_STOPA;
                        end
                        else if (!cmd.scl_in)
                        begin
                            code_next  = OUTCOME_CUT;
                            phase_next = PH_STOPA;
                        end
                        else
                        begin
                            phase_next = PH_CLKLO;
                        end
                    end
                    PH_STOPA: phase_next = PH_STOPB;
                    PH_STOPB: phase_next = PH_STOPC;
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
        end

        rsp.scl_pull_low = (phase_next == PH_CLKLO);
        rsp.sda_pull_low = (phase_next inside {PH_STOPA, PH_STOPB});
        rsp.busy_res     = (phase_next != PH_IDLE);
        rsp.done_res     = done;
        rsp.outcome      = done ? code_next : OUTCOME_CLEAN;
    end

endmodule

`default_nettype wire

### design/isbr_skid.sv
// Result register with a one-entry skid stage, so the input side can take
// one more item while a result waits. Depends on isbr_pkg.
`default_nettype none

module isbr_skid (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  load,
    input  isbr_pkg::rsp_item_t  load_item,
    output logic                 space,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    output isbr_pkg::rsp_item_t  rsp
);
    import isbr_pkg::*;

    logic      out_valid_reg;
    logic      skid_valid_reg;
    rsp_item_t out_item_reg;
    rsp_item_t skid_item_reg;
    logic      out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign space     = !skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // Skid entry goes first; a new item cannot arrive while it is full.
            out_valid_reg  <= skid_valid_reg || load;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : load_item;
        end
        else if (load)
        begin
            skid_item_reg <= load_item;
        end
    end

endmodule

`default_nettype wire

### design/isbr_checker.sv
// Port-level checks for the recovery sequencer, bound to the top level.
// Depends on isbr_pkg and i2c_stuck_bus_recovery_top.
`default_nettype none

module isbr_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  cmd_valid,
    input wire                  cmd_ready,
    input isbr_pkg::cmd_item_t  cmd,
    input wire                  rsp_valid,
    input wire                  rsp_ready,
    input isbr_pkg::rsp_item_t  rsp
);
    import isbr_pkg::*;

    // Hold a waiting command item.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("waiting command item changed or dropped");

    // Hold a stalled result.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or dropped");

    // A finished sequence is no longer busy and drives neither line.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.done_res |-> !rsp.busy_res && !rsp.scl_pull_low
                                      && !rsp.sda_pull_low)
        else $error("done result still shows activity");

    // Outcome only carries a code on the finishing item.
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.done_res || rsp.outcome == OUTCOME_CLEAN)
                      && rsp.outcome <= OUTCOME_CUT)
        else $error("outcome code out of place");

    // Never drive both lines at once, and drive only while busy.
    a_drive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.scl_pull_low || rsp.sda_pull_low)
            |-> rsp.busy_res && !(rsp.scl_pull_low && rsp.sda_pull_low))
        else $error("bad drive combination");

endmodule

bind i2c_stuck_bus_recovery_top isbr_checker u_isbr_checker (.*);

`default_nettype wire

### tb/i2c_stuck_bus_recovery_top_tb.sv
// Self-checking testbench for i2c_stuck_bus_recovery_top: directed and random recovery runs.
// A tick-level model of the sequencer predicts every result item.
// Depends on isbr_pkg and the design sources.
module i2c_stuck_bus_recovery_top_tb;
    import isbr_pkg::*;

    localparam int IDLE_PCT      = 27;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 330;
    localparam int SETTLE_CYCLES = 4;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_ready;
    cmd_item_t                 cmd       = '0;
    logic                      rsp_valid;
    logic                      rsp_ready = 1'b0;
    rsp_item_t                 rsp;

    i2c_stuck_bus_recovery_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sequencer state as the testbench tracks it
    phase_t                   seq_phase  = PH_IDLE;
    logic [15:0]              seq_ticks  = '0;
    logic [CLK_CNT_BITS-1:0]  seq_clocks = '0;
    logic [1:0]               seq_code   = OUTCOME_CLEAN;
    logic [CFG_DATA_BITS-1:0] cfg_pulse  = PULSE_TICKS_RESET;
    logic [CLK_CNT_BITS-1:0]  cfg_clocks = RECOVERY_CLOCKS_RESET;

    rsp_item_t expected_rsp_q[$];

    bit steady = 1'b0;
    int items_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int ignored_starts = 0;
    int outcome_seen[3] = '{0, 0, 0};
    int quiet_cycles = 0;

    // Advance the tracked sequencer by one tick and return the drives and status after it
    function automatic rsp_item_t advance_sequencer(input cmd_item_t item);
        logic [15:0] target;
        logic        done;
        rsp_item_t   r;
        target = (cfg_pulse == 16'd0) ? 16'd1 : cfg_pulse;
        done = 1'b0;
        if (seq_phase == PH_IDLE)
        begin
            if (item.action)
            begin
                seq_phase = PH_SETTLE;
                seq_ticks = '0;
                seq_clocks = '0;
                seq_code = OUTCOME_CLEAN;
            end
        end
        else
        begin
            seq_ticks = seq_ticks + 16'd1;
            if (seq_ticks >= target)
            begin
                seq_ticks = '0;
                case (seq_phase)
                    PH_SETTLE:
                    begin
                        // recover only when SDA is held low with SCL free
                        if (!item.sda_in && item.scl_in)
                        begin
                            if (cfg_clocks == '0)
                            begin
                                seq_code = OUTCOME_FULL;
                                seq_phase = PH_STOPA;
                            end
                            else
                            begin
                                seq_phase = PH_CLKLO;
                            end
                        end
                        else
                        begin
                            seq_code = OUTCOME_CLEAN;
                            seq_phase = PH_IDLE;
                            done = 1'b1;
                        end
                    end
                    PH_CLKLO:
                    begin
                        seq_phase = PH_CLKHI;
                    end
                    PH_CLKHI:
                    begin
                        seq_clocks = seq_clocks + 1'b1;
                        if (seq_clocks >= cfg_clocks)
                        begin
                            seq_code = OUTCOME_FULL;
                            seq_phase = PH_STOPA;
                        end
                        else if (!item.scl_in)
                        begin
                            seq_code = OUTCOME_CUT;
                            seq_phase = PH_STOPA;
                        end
                        else
                        begin
                            seq_phase = PH_CLKLO;
                        end
                    end
                    PH_STOPA:
                    begin
                        seq_phase = PH_STOPB;
                    end
                    PH_STOPB:
                    begin
                        seq_phase = PH_STOPC;
                    end
                    default:
                    begin
                        seq_phase = PH_IDLE;
                        done = 1'b1;
                    end
                endcase
            end
        end
        r.scl_pull_low = (seq_phase == PH_CLKLO);
        r.sda_pull_low = (seq_phase == PH_STOPA) || (seq_phase == PH_STOPB);
        r.busy_res = (seq_phase != PH_IDLE);
        r.done_res = done;
        r.outcome = done ? seq_code : OUTCOME_CLEAN;
        return r;
    endfunction

    task automatic send_tick(input cmd_item_t item);
        rsp_item_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= item;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        if (item.action && seq_phase != PH_IDLE)
            ignored_starts++;
        predicted = advance_sequencer(item);
        if (predicted.done_res)
            outcome_seen[predicted.outcome]++;
        expected_rsp_q.push_back(predicted);
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding result item has been taken
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PULSE_TICKS)
            cfg_pulse = value;
        else
            cfg_clocks = value[CLK_CNT_BITS-1:0];
    endtask

    task automatic set_timing(input logic [15:0] pulse, input logic [15:0] clocks_word);
        write_reg(CFG_PULSE_TICKS, pulse);
        write_reg(CFG_RECOVERY_CLOCKS, clocks_word);
    endtask

    // Issue a start from idle and tick until the sequence ends. With force_stuck the
    // lines read as a stuck bus during the settle wait; otherwise they are random.
    task automatic run_sequence(input bit force_stuck, input int sda_hi_pct,
                                input int scl_lo_pct, input int restart_pct);
        cmd_item_t item;
        item.action = 1'b1;
        item.sda_in = 1'($urandom_range(1));
        item.scl_in = 1'($urandom_range(1));
        send_tick(item);
        while (seq_phase != PH_IDLE)
        begin
            item.action = ($urandom_range(99) < restart_pct);
            if (force_stuck && seq_phase == PH_SETTLE)
            begin
                item.sda_in = 1'b0;
                item.scl_in = 1'b1;
            end
            else
            begin
                item.sda_in = ($urandom_range(99) < sda_hi_pct);
                item.scl_in = !($urandom_range(99) < scl_lo_pct);
            end
            send_tick(item);
        end
    endtask

    task automatic test_reset_defaults();
        // plain ticks with every line combination, a free-bus run at the reset pulse
        // length, then a stuck run with the reset clock count
        for (int i = 0; i < 4; i++)
            send_tick({1'b0, i[1], i[0]});
        run_sequence(1'b0, 100, 0, 0);
        write_reg(CFG_PULSE_TICKS, 16'd1);
        run_sequence(1'b1, 50, 0, 0);
    endtask

    task automatic test_lines_free();
        set_timing(16'd1, 16'd9);
        run_sequence(1'b0, 100, 0, 0);
        run_sequence(1'b0, 0, 100, 0);
        run_sequence(1'b0, 100, 100, 0);
    endtask

    task automatic test_full_clocks();
        // start held high on every tick: all ignored, the finishing tick too
        set_timing(16'd1, 16'd15);
        run_sequence(1'b1, 50, 0, 100);
    endtask

    task automatic test_clock_cut();
        set_timing(16'd2, 16'd15);
        run_sequence(1'b1, 50, 100, 0);
        // the clock limit wins over SCL low on the last clock
        set_timing(16'd2, 16'd1);
        run_sequence(1'b1, 50, 100, 0);
    endtask

    task automatic test_zero_pulse();
        set_timing(16'd0, 16'd3);
        run_sequence(1'b1, 50, 0, 0);
        run_sequence(1'b0, 50, 50, 30);
    endtask

    task automatic test_zero_clocks();
        set_timing(16'd3, 16'd0);
        run_sequence(1'b1, 50, 0, 0);
    endtask

    task automatic test_wide_clock_word();
        // only the low bits of the clock word count
        set_timing(16'd1, 16'hFFF5);
        run_sequence(1'b1, 50, 0, 0);
    endtask

    task automatic test_random();
        int goal;
        int phase_end;
        int kind;
        int setting;
        logic [15:0] pulse;
        logic [15:0] clocks_word;
        goal = items_sent + RANDOM_ITEMS;
        setting = 0;
        while (items_sent < goal)
        begin
            if ($urandom_range(9) == 0)
                pulse = 16'd0;
            else if ($urandom_range(9) == 0)
                pulse = 16'($urandom_range(12, 5));
            else
                pulse = 16'($urandom_range(4, 1));
            clocks_word = 16'($urandom);
            clocks_word[CLK_CNT_BITS-1:0] = CLK_CNT_BITS'($urandom_range(15));
            set_timing(pulse, clocks_word);
            steady = (setting == 0);
            phase_end = items_sent + 140;
            while (items_sent < phase_end && items_sent < goal)
            begin
                kind = $urandom_range(9);
                if (kind <= 5)
                begin
                    case ($urandom_range(3))
                        0, 1: run_sequence(1'b1, 50, 0, 10);
                        2: run_sequence(1'b1, 50, 10, 10);
                        default: run_sequence(1'b1, 50, 40, 10);
                    endcase
                end
                else if (kind <= 7)
                begin
                    run_sequence(1'b0, 30, 30, 10);
                end
                else if (kind == 8)
                begin
                    repeat ($urandom_range(4, 1))
                        send_tick({1'b0, 1'($urandom), 1'($urandom)});
                end
                else
                begin
                    drain_results();
                end
            end
            steady = 1'b0;
            setting++;
        end
    endtask

    // Receiver side: random stalls, then compare each taken item with the oldest prediction
    always @(posedge clk)
    begin : check_results
        rsp_item_t want;
        rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result item: scl %b sda %b busy %b done %b outcome %0d",
                             rsp.scl_pull_low, rsp.sda_pull_low, rsp.busy_res,
                             rsp.done_res, rsp.outcome);
                mismatches++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                results_checked++;
                if (rsp.scl_pull_low !== want.scl_pull_low
                    || rsp.sda_pull_low !== want.sda_pull_low
                    || rsp.busy_res !== want.busy_res
                    || rsp.done_res !== want.done_res
                    || rsp.outcome !== want.outcome)
                begin
                    if (mismatches < 10)
                        $display({"result %0d mismatch: expected scl %b sda %b busy %b done %b ",
                                  "outcome %0d, got scl %b sda %b busy %b done %b outcome %0d"},
                                 results_checked, want.scl_pull_low, want.sda_pull_low,
                                 want.busy_res, want.done_res, want.outcome,
                                 rsp.scl_pull_low, rsp.sda_pull_low, rsp.busy_res,
                                 rsp.done_res, rsp.outcome);
                    mismatches++;
                end
            end
        end
    end

    // Stop the run if neither side moves an item for too long
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_lines_free();
        test_full_clocks();
        test_clock_cut();
        test_zero_pulse();
        test_zero_clocks();
        test_wide_clock_word();
        test_random();
        drain_results();
        $display("covered %0d tick items, %0d results checked, %0d starts ignored while busy",
                 items_sent, results_checked, ignored_starts);
        $display("sequences ended: %0d lines free, %0d all clocks sent, %0d cut short by SCL",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2]);
        if (mismatches == 0 && expected_rsp_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_rsp_q.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
